// ===== rtl/core/bcr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bcr_pkg: shared types and constants of the buffered credit responder
// Holds the opcode codes, the frame record passed from the front end to the
// serialiser, and the sizes of the history, the frame and the frame queue.
// ============================================================================
package bcr_pkg;

    // Byte width used throughout the frame.
    localparam int BYTE_W = 8;

    // History slots carried in every frame, and how many of them hold data.
    localparam int HIST_SLOTS    = 5;
    localparam int HISTORY_DEPTH = 5;

    // Reply frame: four header bytes, the counter, the pairs, the checksum.
    localparam int HDR_BYTES  = 4;
    localparam int FRAME_LEN  = HDR_BYTES + 1 + 2 * HIST_SLOTS + 1;
    localparam int BODY_LEN   = FRAME_LEN - 1;
    localparam int IDX_W      = $clog2(FRAME_LEN);

    // Input stream: seven payload bytes in tdata, the opcode in tuser.
    localparam int IN_DATA_W = 7 * BYTE_W;
    localparam int OP_W      = 2;

    // Frame queue between the front end and the serialiser.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Saturation limit of the pending credit counters.
    localparam logic [BYTE_W-1:0] CNT_MAX = {BYTE_W{1'b1}};

    // Credit and sorter codes pushed for a pulse-input credit.
    localparam logic [BYTE_W-1:0] PULSE_CREDIT = 8'd1;
    localparam logic [BYTE_W-1:0] PULSE_SORTER = 8'd0;

    typedef enum logic [OP_W-1:0] {
        OP_PULSE = 2'd0,
        OP_RESET = 2'd1,
        OP_POLL  = 2'd2
    } opcode_t;

    // Everything the serialiser needs to build one reply frame.
    typedef struct packed {
        logic [HDR_BYTES-1:0][BYTE_W-1:0]  hdr;
        logic [BYTE_W-1:0]                 count;
        logic [HIST_SLOTS-1:0][BYTE_W-1:0] credit;
        logic [HIST_SLOTS-1:0][BYTE_W-1:0] sorter;
    } frame_t;

    // Occupancy flags of the frame queue.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/core/bcr_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bcr_front: input side of the buffered credit responder
// Accepts input transfers, keeps the pending credit counts, the event counter
// and the credit/sorter history, and queues a frame record for every poll.
// ============================================================================
module bcr_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata, from bit 0 up: hdr_dest, hdr_count, hdr_source, hdr_header,
    // acceptor_event, credit_code, sorter_code
    input  logic [bcr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: opcode
    input  logic [bcr_pkg::OP_W-1:0]  s_axis_tuser,
    input  bcr_pkg::q_stat_t          q_stat,
    output logic                      frame_push,
    output bcr_pkg::frame_t           frame_data
);
    import bcr_pkg::*;

    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] last_ev_reg, last_ev_next;
    logic [BYTE_W-1:0] real_reg, real_next;
    logic [BYTE_W-1:0] pulse_reg, pulse_next;
    logic [HIST_SLOTS-1:0][BYTE_W-1:0] credit_reg, credit_next;
    logic [HIST_SLOTS-1:0][BYTE_W-1:0] sorter_reg, sorter_next;

    opcode_t           op;
    logic              accept;
    logic [BYTE_W-1:0] ev, cc, sc;
    logic [BYTE_W-1:0] real_bumped;
    logic              push_en;
    logic [BYTE_W-1:0] push_credit, push_sorter;

    // Field unpacking.
    assign op     = opcode_t'(s_axis_tuser);
    assign ev     = s_axis_tdata[4*BYTE_W +: BYTE_W];
    assign cc     = s_axis_tdata[5*BYTE_W +: BYTE_W];
    assign sc     = s_axis_tdata[6*BYTE_W +: BYTE_W];

    // Any input item waits while the frame queue has no room.
    assign s_axis_tready = ~q_stat.full;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // Counter updates and the choice of which credit, if any, is pushed.
    always_comb
    begin
        count_next   = count_reg;
        last_ev_next = last_ev_reg;
        real_next    = real_reg;
        pulse_next   = pulse_reg;
        real_bumped  = real_reg;
        push_en      = 1'b0;
        push_credit  = PULSE_CREDIT;
        push_sorter  = PULSE_SORTER;
        frame_push   = 1'b0;
        if (accept)
        begin
            unique case (op)
                OP_PULSE:
                begin
                    if (pulse_reg != CNT_MAX)
                    begin
                        pulse_next = pulse_reg + 8'd1;
                    end
                end
                OP_RESET:
                begin
                    count_next = '0;
                end
                OP_POLL:
                begin
                    frame_push = 1'b1;
                    // A new acceptor event value queues one real credit.
                    if (ev != last_ev_reg)
                    begin
                        last_ev_next = ev;
                        if (real_reg != CNT_MAX)
                        begin
                            real_bumped = real_reg + 8'd1;
                        end
                    end
                    real_next = real_bumped;
                    if ((pulse_reg != '0) && (real_bumped == '0))
                    begin
                        pulse_next = pulse_reg - 8'd1;
                        push_en    = 1'b1;
                    end
                    else if (real_bumped != '0)
                    begin
                        real_next   = real_bumped - 8'd1;
                        push_en     = 1'b1;
                        push_credit = cc;
                        push_sorter = sc;
                    end
                    if (push_en)
                    begin
                        count_next = count_reg + 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // History shift on a push, clearing on a reset poll.
    always_comb
    begin
        credit_next = credit_reg;
        sorter_next = sorter_reg;
        if (accept && (op == OP_RESET))
        begin
            credit_next = '0;
            sorter_next = '0;
        end
        else if (push_en)
        begin
            for (int k = 0; k < HIST_SLOTS; k++)
            begin
                if (k >= HISTORY_DEPTH)
                begin
                    credit_next[k] = '0;
                    sorter_next[k] = '0;
                end
                else if (k == 0)
                begin
                    credit_next[k] = push_credit;
                    sorter_next[k] = push_sorter;
                end
                else
                begin
                    credit_next[k] = credit_reg[k-1];
                    sorter_next[k] = sorter_reg[k-1];
                end
            end
        end
    end

    // The queued frame reflects the state after this poll's push.
    always_comb
    begin
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            frame_data.hdr[k] = s_axis_tdata[k*BYTE_W +: BYTE_W];
        end
        frame_data.count  = count_next;
        frame_data.credit = credit_next;
        frame_data.sorter = sorter_next;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            last_ev_reg <= '0;
            real_reg    <= '0;
            pulse_reg   <= '0;
            credit_reg  <= '0;
            sorter_reg  <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            last_ev_reg <= last_ev_next;
            real_reg    <= real_next;
            pulse_reg   <= pulse_next;
            credit_reg  <= credit_next;
            sorter_reg  <= sorter_next;
        end
    end

endmodule

// ===== rtl/core/bcr_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bcr_queue: frame record queue
// A short first-in first-out store of frame records that lets the front end
// take further items while the serialiser is still sending a frame.
// ============================================================================
module bcr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bcr_pkg::frame_t   push_data,
    input  logic              pop,
    output bcr_pkg::frame_t   head_data,
    output bcr_pkg::q_stat_t  stat
);
    import bcr_pkg::*;

    frame_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push & ~stat.full;
    assign do_pop     = pop & ~stat.empty;
    assign head_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, written at the tail only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/bcr_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// bcr_back: reply frame serialiser
// Sends the frame record at the head of the queue one byte per transfer and
// appends the two's-complement checksum, accumulated as the bytes go out.
// ============================================================================
module bcr_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bcr_pkg::frame_t          head_data,
    input  bcr_pkg::q_stat_t         q_stat,
    output logic                     pop,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // tdata: reply_byte
    output logic [bcr_pkg::BYTE_W-1:0] m_axis_tdata,
    output logic                     m_axis_tlast
);
    import bcr_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic [BYTE_W-1:0] body [BODY_LEN];
    logic [BYTE_W-1:0] cur_byte;
    logic              load, at_end;

    // Frame body laid out in sending order.
    always_comb
    begin
        for (int k = 0; k < HDR_BYTES; k++)
        begin
            body[k] = head_data.hdr[k];
        end
        body[HDR_BYTES] = head_data.count;
        for (int k = 0; k < HIST_SLOTS; k++)
        begin
            body[HDR_BYTES + 1 + 2*k] = head_data.credit[k];
            body[HDR_BYTES + 2 + 2*k] = head_data.sorter[k];
        end
    end

    // The output register takes a new byte whenever it is empty or drained.
    assign load     = ~q_stat.empty & (~out_valid_reg | m_axis_tready);
    assign at_end   = (idx_reg == IDX_W'(FRAME_LEN - 1));
    assign cur_byte = at_end ? (BYTE_W'(0) - sum_reg) : body[idx_reg];
    assign pop      = load & at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = cur_byte;
            out_last_next  = at_end;
            idx_next       = at_end ? '0 : idx_reg + 1'b1;
            // Running sum restarts with the first byte of each frame.
            sum_next       = (idx_reg == '0) ? cur_byte : sum_reg + cur_byte;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
            out_last_next  = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    // The frame end marker is only ever shown with a valid byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_last_reg |-> out_valid_reg)
        else $error("bcr_back: tlast without tvalid");

    // Once the checksum byte is loaded, the next frame starts at byte zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_last_reg |-> (idx_reg == '0))
        else $error("bcr_back: byte index not rewound after checksum");

    // Part way through a frame its record must still be at the queue head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> !q_stat.empty)
        else $error("bcr_back: frame record lost mid-frame");
`endif

endmodule

// ===== rtl/core/buffered_credit_responder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// buffered_credit_responder: buffered credit poll responder
// Merges pulse credits and coin acceptor events into a credit history and
// answers each poll with a 16-byte reply frame ending in a checksum.
// ============================================================================
// Pulse credit and reset poll items produce no output. A buffered credit
// poll produces a 16-byte reply frame, sent one byte per cycle from an
// output register while the receiver takes each byte, and further items
// are accepted while the frame is sent. The front end updates the credit
// state in the cycle an item is accepted and places the frame record in a
// two-entry queue; with the serialiser idle, the record is registered in
// the queue and then in the output register, which presents the first
// byte. The input stalls only while that queue is full.
module buffered_credit_responder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, from bit 0 up: hdr_dest, hdr_count, hdr_source, hdr_header,
    // acceptor_event, credit_code, sorter_code
    input  logic [bcr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: opcode
    input  logic [bcr_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: reply_byte
    output logic [bcr_pkg::BYTE_W-1:0]    m_axis_tdata,
    // tlast: last_byte
    output logic                          m_axis_tlast
);
    import bcr_pkg::*;

    logic    frame_push;
    frame_t  frame_data;
    frame_t  head_data;
    q_stat_t q_stat;
    logic    frame_pop;

    // Item acceptance and state update.
    bcr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .frame_push    (frame_push),
        .frame_data    (frame_data)
    );

    // Frame records waiting to be sent.
    bcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (frame_push),
        .push_data (frame_data),
        .pop       (frame_pop),
        .head_data (head_data),
        .stat      (q_stat)
    );

    // Byte serialiser and checksum.
    bcr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_data     (head_data),
        .q_stat        (q_stat),
        .pop           (frame_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== verif/buffered_credit_responder_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// buffered_credit_responder_tb: self-checking bench for the credit responder
// Drives pulse credits, reset polls, unused codes and buffered credit polls
// into the block, predicts every 16-byte reply frame from its own model of
// the credit state and checks each byte and its end marker as it is taken.
// ============================================================================
module buffered_credit_responder_tb;

    import bcr_pkg::*;

    // Opcode that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int TAIL_CYCLES  = 40;

    // One expected byte of a reply frame.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } reply_byte_t;

    // Keeps a copy of the credit state, works out the reply frame of every
    // poll and checks the bytes that leave the block against it.
    class credit_ledger;
        logic [BYTE_W-1:0] event_count;
        logic [BYTE_W-1:0] credit_hist [HIST_SLOTS];
        logic [BYTE_W-1:0] sorter_hist [HIST_SLOTS];
        logic [BYTE_W-1:0] last_event;
        logic [BYTE_W-1:0] real_pending;
        logic [BYTE_W-1:0] pulse_pending;
        reply_byte_t       bytes_due [$];
        int                mismatches;
        int                byte_pos;

        function new();
            clear_history();
            last_event    = '0;
            real_pending  = '0;
            pulse_pending = '0;
            mismatches    = 0;
            byte_pos      = 0;
        endfunction

        function void clear_history();
            int k;
            event_count = '0;
            for (k = 0; k < HIST_SLOTS; k++)
            begin
                credit_hist[k] = '0;
                sorter_hist[k] = '0;
            end
        endfunction

        // Newest pair goes to slot 0; slots past the configured depth read zero.
        function void push_pair(input logic [BYTE_W-1:0] credit,
                                input logic [BYTE_W-1:0] sorter);
            int k;
            for (k = HIST_SLOTS - 1; k > 0; k--)
            begin
                credit_hist[k] = credit_hist[k - 1];
                sorter_hist[k] = sorter_hist[k - 1];
            end
            credit_hist[0] = credit;
            sorter_hist[0] = sorter;
            for (k = HISTORY_DEPTH; k < HIST_SLOTS; k++)
            begin
                credit_hist[k] = '0;
                sorter_hist[k] = '0;
            end
            event_count = event_count + 1'b1;
        endfunction

        function void accept_item(input logic [OP_W-1:0]      op,
                                  input logic [IN_DATA_W-1:0] data);
            logic [BYTE_W-1:0] frame [FRAME_LEN];
            logic [BYTE_W-1:0] sum;
            logic [BYTE_W-1:0] ev;
            reply_byte_t       entry;
            int                k;
            ev = data[4*BYTE_W +: BYTE_W];
            case (op)
                OP_PULSE:
                begin
                    if (pulse_pending != CNT_MAX)
                        pulse_pending = pulse_pending + 1'b1;
                end
                OP_RESET:
                begin
                    clear_history();
                end
                OP_POLL:
                begin
                    // A changed acceptor event queues one real credit.
                    if (ev != last_event)
                    begin
                        last_event = ev;
                        if (real_pending != CNT_MAX)
                            real_pending = real_pending + 1'b1;
                    end
                    // Pulse credits are only taken when no real credit waits.
                    if (pulse_pending != 0 && real_pending == 0)
                    begin
                        pulse_pending = pulse_pending - 1'b1;
                        push_pair(PULSE_CREDIT, PULSE_SORTER);
                    end
                    if (real_pending != 0)
                    begin
                        real_pending = real_pending - 1'b1;
                        push_pair(data[5*BYTE_W +: BYTE_W], data[6*BYTE_W +: BYTE_W]);
                    end
                    // Build the frame and close it with the checksum.
                    for (k = 0; k < HDR_BYTES; k++)
                        frame[k] = data[k*BYTE_W +: BYTE_W];
                    frame[HDR_BYTES] = event_count;
                    for (k = 0; k < HIST_SLOTS; k++)
                    begin
                        frame[HDR_BYTES + 1 + 2*k] = credit_hist[k];
                        frame[HDR_BYTES + 2 + 2*k] = sorter_hist[k];
                    end
                    sum = '0;
                    for (k = 0; k < BODY_LEN; k++)
                        sum = sum + frame[k];
                    frame[BODY_LEN] = 8'd0 - sum;
                    for (k = 0; k < FRAME_LEN; k++)
                    begin
                        entry.value = frame[k];
                        entry.last  = (k == FRAME_LEN - 1);
                        bytes_due.push_back(entry);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(input string msg);
            mismatches++;
            $display("%0t ns mismatch: %s", $time, msg);
        endtask

        task check_byte(input logic [BYTE_W-1:0] value, input logic last);
            reply_byte_t due;
            if (bytes_due.size() == 0)
            begin
                report($sformatf("byte %02h (last %b) with no frame due", value, last));
                return;
            end
            due = bytes_due.pop_front();
            if (value !== due.value)
                report($sformatf("frame byte %0d is %02h, expected %02h",
                                 byte_pos, value, due.value));
            if (last !== due.last)
                report($sformatf("frame byte %0d last is %b, expected %b",
                                 byte_pos, last, due.last));
            byte_pos = due.last ? 0 : byte_pos + 1;
        endtask

        function int pending();
            return bytes_due.size();
        endfunction
    endclass

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata   = '0;
    logic [OP_W-1:0]      s_axis_tuser   = OP_PULSE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [BYTE_W-1:0]    m_axis_tdata;
    logic                 m_axis_tlast;

    credit_ledger ledger = new();

    // Sender burst state.
    int   burst_left = 0;
    logic no_gaps    = 1'b0;

    // Receiver stall state.
    logic long_hold_req    = 1'b0;
    logic long_hold_done   = 1'b0;
    int   long_hold_cycles = 0;
    int   pattern_left     = 0;
    int   stall_pct        = 0;
    int   cycle_count      = 0;

    buffered_credit_responder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: one long hold-off on request, otherwise a changing stall mix.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready    <= 1'b0;
            long_hold_cycles <= 0;
            long_hold_done   <= 1'b0;
            pattern_left     <= 0;
            stall_pct        <= 0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            m_axis_tready <= 1'b0;
            if (long_hold_cycles == LONG_HOLD - 1)
                long_hold_done <= 1'b1;
            long_hold_cycles <= long_hold_cycles + 1;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 20;
                    2:       stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
                pattern_left <= $urandom_range(50, 300);
            end
            else
            begin
                pattern_left <= pattern_left - 1;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Every byte taken by the receiver is checked.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_byte(m_axis_tdata, m_axis_tlast);
    end

    // Random payload with a chosen acceptor event byte.
    function automatic logic [IN_DATA_W-1:0] payload_with_event(input logic [BYTE_W-1:0] ev);
        logic [IN_DATA_W-1:0] data;
        data = IN_DATA_W'({$urandom, $urandom});
        data[4*BYTE_W +: BYTE_W] = ev;
        return data;
    endfunction

    // Offers one item, with a random gap at the start of each burst, and
    // waits for the transfer.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IN_DATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4 || no_gaps) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        ledger.accept_item(op, data);
    endtask

    // Sender holds off until every expected byte has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (ledger.pending() != 0);
    endtask

    // Random mix; ignored codes are not counted.
    task automatic random_chunk(input int n);
        int                done_items;
        int                pick;
        logic [BYTE_W-1:0] ev;
        done_items = 0;
        while (done_items < n)
        begin
            pick = $urandom_range(0, 99);
            ev   = ($urandom_range(0, 1) == 1) ? ledger.last_event : BYTE_W'($urandom);
            if (pick < 25)
                send_item(OP_PULSE, payload_with_event(ev));
            else if (pick < 30)
                send_item(OP_RESET, payload_with_event(ev));
            else if (pick < 35)
                send_item(OP_UNUSED, payload_with_event(ev));
            else
                send_item(OP_POLL, payload_with_event(ev));
            if (pick < 30 || pick >= 35)
                done_items++;
        end
    endtask

    initial
    begin
        int i;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fields at their extremes, pulse and real credits, history
        // overflow, the ignored code and reset polls.
        send_item(OP_POLL, '0);
        send_item(OP_POLL, {8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF});
        send_item(OP_PULSE, payload_with_event(8'h00));
        send_item(OP_PULSE, payload_with_event(8'hFF));
        send_item(OP_POLL, {8'h00, 8'h00, 8'h00, 32'h0000_0000});
        send_item(OP_POLL, {8'hFF, 8'hFF, 8'hFF, 32'h1234_5678});
        send_item(OP_POLL, {8'h00, 8'h5A, 8'hFF, 32'hA5A5_A5A5});
        send_item(OP_POLL, {8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF});
        for (i = 1; i <= 5; i++)
            send_item(OP_POLL, {8'(8'hF0 ^ i), 8'(8'h80 | i), 8'(i), 32'h00FF_00FF});
        send_item(OP_UNUSED, '1);
        send_item(OP_POLL, {8'h11, 8'h22, 8'h05, 32'h0102_0304});
        send_item(OP_RESET, '1);
        send_item(OP_POLL, {8'h33, 8'h44, 8'h05, 32'hFEDC_BA98});
        send_item(OP_RESET, '0);
        send_item(OP_POLL, {8'hFF, 8'h00, 8'hAA, 32'h8000_0001});

        // Pulse count saturation, then a run of unchanged-event polls that
        // each use up one of the kept credits.
        repeat (258) send_item(OP_PULSE, payload_with_event(BYTE_W'($urandom)));
        repeat (16) send_item(OP_POLL, payload_with_event(ledger.last_event));
        wait_drained();

        random_chunk(50);

        // Receiver holds off while polls keep coming, so the input backs up.
        long_hold_req <= 1'b1;
        no_gaps = 1'b1;
        repeat (12) send_item(OP_POLL, payload_with_event(BYTE_W'($urandom)));
        no_gaps = 1'b0;

        random_chunk(50);
        wait_drained();
        random_chunk(45);

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (ledger.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
